>>> rtl/core/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// shared types and constants for the 2d vector normalize block
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int FIELD_W        = 16;
    localparam int LEN_W          = 25;
    localparam int DIR_W          = 16;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int DIR_FRAC_DEF   = 14;
    localparam int QUEUE_DEPTH    = 4;

    typedef struct packed {
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] end_x;
        logic signed [FIELD_W-1:0] end_y;
    } req_t;

    typedef struct packed {
        logic        [LEN_W-1:0] length_q8;
        logic signed [DIR_W-1:0] dir_x_q14;
        logic signed [DIR_W-1:0] dir_y_q14;
        logic                    zero_length;
    } res_t;

    // queue status seen by the front and the back part
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> rtl/core/vn_queue.sv
// ----------------------------------------------------------------------------
// vn_queue
// short fifo between the front and the back part
// ----------------------------------------------------------------------------
module vn_queue
    import vn_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [W-1:0]  wdata,
    input  logic          pop,
    output logic [W-1:0]  rdata,
    output queue_status_t status
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]  mem_reg [0:QUEUE_DEPTH-1];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW:0]   count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == AW'(QUEUE_DEPTH-1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == AW'(QUEUE_DEPTH-1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata        = mem_reg[rptr_reg];
    assign status.full  = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

>>> rtl/core/vn_front.sv
// ----------------------------------------------------------------------------
// vn_front
// takes requests, forms the difference vector and its squares
// ----------------------------------------------------------------------------
module vn_front
    import vn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int SQ_W        = 2*COORD_WIDTH + 2,
    parameter int ENT_W       = 3*SQ_W + 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             stall,
    input  req_t             req,
    input  queue_status_t    qstat,
    output logic             push,
    output logic [ENT_W-1:0] entry
);

    localparam int CW = COORD_WIDTH;

    logic          fv_reg;
    logic [CW:0]   ax_reg, ay_reg;
    logic          sx_reg, sy_reg;
    logic [CW:0]   dx, dy;
    logic [CW:0]   ax, ay;
    logic [SQ_W-1:0] axsq, aysq, ssum;
    logic          accept;

    // read a field as CW bits, sign extended to CW+1
    function automatic logic [CW:0] coord(logic [FIELD_W-1:0] f);
        logic [FIELD_W+CW-1:0] t;
        t = {{CW{f[FIELD_W-1]}}, f};
        return {t[CW-1], t[CW-1:0]};
    endfunction

    assign dx = coord(req.end_x) - coord(req.start_x);
    assign dy = coord(req.end_y) - coord(req.start_y);
    assign ax = dx[CW] ? (~dx + 1'b1) : dx;
    assign ay = dy[CW] ? (~dy + 1'b1) : dy;

    assign stall  = fv_reg && qstat.full;
    assign accept = valid && !stall;
    assign push   = fv_reg && !qstat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (accept)
        begin
            fv_reg <= 1'b1;
        end
        else if (push)
        begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= ax;
            ay_reg <= ay;
            sx_reg <= dx[CW];
            sy_reg <= dy[CW];
        end
    end

    assign axsq  = SQ_W'(ax_reg * ax_reg);
    assign aysq  = SQ_W'(ay_reg * ay_reg);
    assign ssum  = axsq + aysq;
    assign entry = {ssum, axsq, aysq, sx_reg, sy_reg, (ssum == '0)};

endmodule

>>> rtl/core/vn_back.sv
// ----------------------------------------------------------------------------
// vn_back
// pipelined square roots and divides, one digit per stage, with output register
// ----------------------------------------------------------------------------
module vn_back
    import vn_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_DEF,
    parameter int SQ_W          = 2*COORD_WIDTH + 2,
    parameter int ENT_W         = 3*SQ_W + 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ENT_W-1:0] entry,
    input  queue_status_t    qstat,
    output logic             pop,
    output logic             valid,
    input  logic             stall,
    output res_t             res
);

    localparam int LK  = COORD_WIDTH + 9;      // length root bits
    localparam int LR  = LK + 2;
    localparam int DV  = 2*DIR_FRAC_BITS + 1;  // quotient bits
    localparam int DK  = DIR_FRAC_BITS + 1;    // direction root bits
    localparam int DR  = DK + 2;
    localparam int QW  = SQ_W + 1;
    localparam int NST = (LK > DV + DK) ? LK : DV + DK;

    logic [NST:0]    v_reg;
    logic [SQ_W-1:0] s_reg    [0:NST];
    logic [SQ_W-1:0] axsq_reg [0:NST];
    logic [SQ_W-1:0] aysq_reg [0:NST];
    logic            sx_reg   [0:NST];
    logic            sy_reg   [0:NST];
    logic            z_reg    [0:NST];
    logic [LR-1:0]   lrem_reg [0:NST];
    logic [LK-1:0]   lroot_reg[0:NST];
    logic [2*LK-1:0] ln_reg   [0:NST];
    logic [QW-1:0]   xdr_reg  [0:NST];
    logic [QW-1:0]   ydr_reg  [0:NST];
    logic [DV-1:0]   xq_reg   [0:NST];
    logic [DV-1:0]   yq_reg   [0:NST];
    logic [DR-1:0]   xsr_reg  [0:NST];
    logic [DR-1:0]   ysr_reg  [0:NST];
    logic [DK-1:0]   xrt_reg  [0:NST];
    logic [DK-1:0]   yrt_reg  [0:NST];
    logic [2*DK-1:0] xn_reg   [0:NST];
    logic [2*DK-1:0] yn_reg   [0:NST];

    logic            out_v_reg;
    res_t            out_reg;
    logic            advance;

    logic [SQ_W-1:0] e_s, e_axsq, e_aysq;
    logic            e_sx, e_sy, e_z;

    function automatic logic [LR+LK-1:0] len_step(logic [LR-1:0] rem,
                                                   logic [LK-1:0] root,
                                                   logic [1:0] bits);
        logic [LR-1:0] sh;
        logic [LR-1:0] trial;
        logic          ge;
        sh    = {rem[LR-3:0], bits};
        trial = {root, 2'b01};
        ge    = (sh >= trial);
        return {(ge ? sh - trial : sh), root[LK-2:0], ge};
    endfunction

    function automatic logic [DR+DK-1:0] dir_step(logic [DR-1:0] rem,
                                                   logic [DK-1:0] root,
                                                   logic [1:0] bits);
        logic [DR-1:0] sh;
        logic [DR-1:0] trial;
        logic          ge;
        sh    = {rem[DR-3:0], bits};
        trial = {root, 2'b01};
        ge    = (sh >= trial);
        return {(ge ? sh - trial : sh), root[DK-2:0], ge};
    endfunction

    function automatic logic [QW+DV-1:0] div_step(logic [QW-1:0] rem,
                                                   logic [DV-1:0] q,
                                                   logic [SQ_W-1:0] d,
                                                   logic b);
        logic [QW-1:0] sh;
        logic          ge;
        sh = {rem[QW-2:0], b};
        ge = (sh >= {1'b0, d});
        return {(ge ? sh - {1'b0, d} : sh), q[DV-2:0], ge};
    endfunction

    assign {e_s, e_axsq, e_aysq, e_sx, e_sy, e_z} = entry;

    assign advance = !out_v_reg || !stall;
    assign pop     = advance && !qstat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg     <= {v_reg[NST-1:0], !qstat.empty};
            out_v_reg <= v_reg[NST];
        end
    end

    // stage 0 takes the queue head
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s_reg[0]     <= e_s;
            axsq_reg[0]  <= e_axsq;
            aysq_reg[0]  <= e_aysq;
            sx_reg[0]    <= e_sx;
            sy_reg[0]    <= e_sy;
            z_reg[0]     <= e_z;
            lrem_reg[0]  <= '0;
            lroot_reg[0] <= '0;
            ln_reg[0]    <= {e_s, 16'h0000};
            // x^2/2 < s, so the divide starts below the divisor
            xdr_reg[0]   <= {2'b00, e_axsq[SQ_W-1:1]};
            ydr_reg[0]   <= {2'b00, e_aysq[SQ_W-1:1]};
            xq_reg[0]    <= '0;
            yq_reg[0]    <= '0;
            xsr_reg[0]   <= '0;
            ysr_reg[0]   <= '0;
            xrt_reg[0]   <= '0;
            yrt_reg[0]   <= '0;
            xn_reg[0]    <= '0;
            yn_reg[0]    <= '0;
        end
    end

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        logic [LR-1:0]   lrem_next;
        logic [LK-1:0]   lroot_next;
        logic [2*LK-1:0] ln_next;
        logic [QW-1:0]   xdr_next, ydr_next;
        logic [DV-1:0]   xq_next, yq_next;
        logic [DR-1:0]   xsr_next, ysr_next;
        logic [DK-1:0]   xrt_next, yrt_next;
        logic [2*DK-1:0] xn_next, yn_next;

        always_comb
        begin
            lrem_next  = lrem_reg[s];
            lroot_next = lroot_reg[s];
            ln_next    = ln_reg[s];
            xdr_next   = xdr_reg[s];
            ydr_next   = ydr_reg[s];
            xq_next    = xq_reg[s];
            yq_next    = yq_reg[s];
            xsr_next   = xsr_reg[s];
            ysr_next   = ysr_reg[s];
            xrt_next   = xrt_reg[s];
            yrt_next   = yrt_reg[s];
            xn_next    = xn_reg[s];
            yn_next    = yn_reg[s];
            if (s < LK)
            begin
                {lrem_next, lroot_next} = len_step(lrem_reg[s], lroot_reg[s],
                                                   ln_reg[s][2*LK-1 -: 2]);
                ln_next = {ln_reg[s][2*LK-3:0], 2'b00};
            end
            if (s < DV)
            begin
                // only the first fed numerator bit can be nonzero
                {xdr_next, xq_next} = div_step(xdr_reg[s], xq_reg[s], s_reg[s],
                                               (s == 0) ? axsq_reg[s][0] : 1'b0);
                {ydr_next, yq_next} = div_step(ydr_reg[s], yq_reg[s], s_reg[s],
                                               (s == 0) ? aysq_reg[s][0] : 1'b0);
                if (s == DV - 1)
                begin
                    xn_next = {1'b0, xq_next};
                    yn_next = {1'b0, yq_next};
                end
            end
            else if (s < DV + DK)
            begin
                {xsr_next, xrt_next} = dir_step(xsr_reg[s], xrt_reg[s],
                                                xn_reg[s][2*DK-1 -: 2]);
                {ysr_next, yrt_next} = dir_step(ysr_reg[s], yrt_reg[s],
                                                yn_reg[s][2*DK-1 -: 2]);
                xn_next = {xn_reg[s][2*DK-3:0], 2'b00};
                yn_next = {yn_reg[s][2*DK-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                s_reg[s+1]     <= s_reg[s];
                axsq_reg[s+1]  <= axsq_reg[s];
                aysq_reg[s+1]  <= aysq_reg[s];
                sx_reg[s+1]    <= sx_reg[s];
                sy_reg[s+1]    <= sy_reg[s];
                z_reg[s+1]     <= z_reg[s];
                lrem_reg[s+1]  <= lrem_next;
                lroot_reg[s+1] <= lroot_next;
                ln_reg[s+1]    <= ln_next;
                xdr_reg[s+1]   <= xdr_next;
                ydr_reg[s+1]   <= ydr_next;
                xq_reg[s+1]    <= xq_next;
                yq_reg[s+1]    <= yq_next;
                xsr_reg[s+1]   <= xsr_next;
                ysr_reg[s+1]   <= ysr_next;
                xrt_reg[s+1]   <= xrt_next;
                yrt_reg[s+1]   <= yrt_next;
                xn_reg[s+1]    <= xn_next;
                yn_reg[s+1]    <= yn_next;
            end
        end
    end

    logic [LK+LEN_W-1:0] len_ext;
    logic [DK+DIR_W-1:0] dx_ext, dy_ext;
    logic [DIR_W-1:0]    dx_mag, dy_mag;

    assign len_ext = {{LEN_W{1'b0}}, lroot_reg[NST]};
    assign dx_ext  = {{DIR_W{1'b0}}, xrt_reg[NST]};
    assign dy_ext  = {{DIR_W{1'b0}}, yrt_reg[NST]};
    assign dx_mag  = dx_ext[DIR_W-1:0];
    assign dy_mag  = dy_ext[DIR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (z_reg[NST])
            begin
                out_reg.length_q8   <= '0;
                out_reg.dir_x_q14   <= '0;
                out_reg.dir_y_q14   <= '0;
                out_reg.zero_length <= 1'b1;
            end
            else
            begin
                out_reg.length_q8   <= len_ext[LEN_W-1:0];
                out_reg.dir_x_q14   <= sx_reg[NST] ? (~dx_mag + 1'b1) : dx_mag;
                out_reg.dir_y_q14   <= sy_reg[NST] ? (~dy_mag + 1'b1) : dy_mag;
                out_reg.zero_length <= 1'b0;
            end
        end
    end

    assign valid = out_v_reg;
    assign res   = out_reg;

endmodule

>>> rtl/core/vector_normalize_2d.sv
// ----------------------------------------------------------------------------
// vector_normalize_2d
// distance and unit direction between two points
// ----------------------------------------------------------------------------
// One request enters per clock and one result leaves per clock for as long as
// the result side does not stall. A request passes the front register, the
// four-entry queue, then the back pipeline of 1 + max(COORD_WIDTH+9,
// 3*DIR_FRAC_BITS+2) stages (45 at the defaults, set by the restoring divide
// followed by the direction square root, one digit per stage) and the output
// register. The length is floor(sqrt(dx^2+dy^2) * 2^8); each direction
// component is truncated toward zero. Coinciding points give zero length,
// zero direction and zero_length.
module vector_normalize_2d
    import vn_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int SQ_W  = 2*COORD_WIDTH + 2;
    localparam int ENT_W = 3*SQ_W + 3;

    logic             push, pop;
    logic [ENT_W-1:0] f_entry, q_entry;
    queue_status_t    qstat;

    vn_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .SQ_W        (SQ_W),
        .ENT_W       (ENT_W)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (req_valid),
        .stall (req_stall),
        .req   (req),
        .qstat (qstat),
        .push  (push),
        .entry (f_entry)
    );

    vn_queue #(
        .W (ENT_W)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (f_entry),
        .pop    (pop),
        .rdata  (q_entry),
        .status (qstat)
    );

    vn_back #(
        .COORD_WIDTH   (COORD_WIDTH),
        .DIR_FRAC_BITS (DIR_FRAC_BITS),
        .SQ_W          (SQ_W),
        .ENT_W         (ENT_W)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .entry (q_entry),
        .qstat (qstat),
        .pop   (pop),
        .valid (res_valid),
        .stall (res_stall),
        .res   (res)
    );

    // coinciding points carry no length and no direction
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.zero_length |-> res.length_q8 == '0)
        else $error("zero_length with nonzero length");

    a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.zero_length |-> res.dir_x_q14 == '0 && res.dir_y_q14 == '0)
        else $error("zero_length with nonzero direction");

    // the front only holds off while it has a request waiting and the queue is full
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |=> $past(qstat.full))
        else $error("request stalled without a full queue");

endmodule

>>> tb/tb_vector_normalize_2d.sv
// ----------------------------------------------------------------------------
// tb_vector_normalize_2d
// self-checking bench for the 2d vector normalize block
// ----------------------------------------------------------------------------
// Requests go in through a driver task with random gaps. Each accepted request
// is run through an integer model of the distance and direction, and the
// expected result is queued. A monitor applies random stalls on the result
// side and compares each accepted result, field by field, with the oldest
// entry in that queue.
// The tests run in turn: directed corner cases, random point pairs, a long
// result-side hold-off while requests keep coming, and a full drain pause.
module tb_vector_normalize_2d;
    import vn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC         = DIR_FRAC_DEF;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic res_valid;
    logic res_stall;
    res_t res;

    res_t expected_res_q[$];
    int   mismatch_cnt;
    int   idle_cycles;
    int   hold_request;
    bit   no_gaps;

    vector_normalize_2d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #2 clk = ~clk;

    function automatic bit [63:0] isqrt64(bit [63:0] n);
        bit [63:0] root;
        bit [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // sign(c) * floor(|c| * 2^FRAC / sqrt(s)), done as isqrt(floor(c^2 * 4^FRAC / s))
    function automatic logic [DIR_W-1:0] unit_component(longint c, bit [63:0] s);
        bit [63:0] a;
        bit [63:0] q;
        a = (c < 0) ? -c : c;
        q = isqrt64(((a * a) << (2 * FRAC)) / s);
        if (c < 0)
            q = -q;
        return q[DIR_W-1:0];
    endfunction

    function automatic res_t normalize(req_t r);
        res_t      o;
        longint    dx;
        longint    dy;
        bit [63:0] s;
        bit [63:0] l;
        dx = longint'(r.end_x) - longint'(r.start_x);
        dy = longint'(r.end_y) - longint'(r.start_y);
        s  = dx * dx + dy * dy;
        o  = '0;
        if (s == 0)
        begin
            o.zero_length = 1'b1;
        end
        else
        begin
            l           = isqrt64(s << 16);
            o.length_q8 = l[LEN_W-1:0];
            o.dir_x_q14 = unit_component(dx, s);
            o.dir_y_q14 = unit_component(dy, s);
        end
        return o;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a rising edge, returns at the edge where the request is taken
    task automatic send_req(req_t r);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        expected_res_q.push_back(normalize(r));
    endtask

    task automatic send_points(int sx, int sy, int ex, int ey);
        req_t r;
        r.start_x = FIELD_W'(sx);
        r.start_y = FIELD_W'(sy);
        r.end_x   = FIELD_W'(ex);
        r.end_y   = FIELD_W'(ey);
        send_req(r);
    endtask

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic test_directed();
        send_points(0, 0, 0, 0);
        send_points(-32768, 32767, -32768, 32767);
        send_points(0, 0, 100, 0);
        send_points(0, 0, -100, 0);
        send_points(5, 0, 5, 1);
        send_points(5, 0, 5, -32768);
        send_points(-32768, -32768, 32767, 32767);
        send_points(32767, 32767, -32768, -32768);
        send_points(32767, -32768, -32768, 32767);
        send_points(-32768, 32767, 32767, -32768);
        send_points(-32768, 0, 32767, 0);
        send_points(0, 32767, 0, -32768);
        send_points(0, 0, 1, 1);
        send_points(0, 0, -1, 1);
        send_points(0, 0, 3, 4);
        send_points(0, 0, -3, -4);
        send_points(1, 1, 2, 3);
        send_points(-1, -1, 0, 0);
        send_points(-21846, 21845, 10922, -10923);
    endtask

    task automatic test_random(int count);
        int sx;
        int sy;
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sx  = rand_coord();
            sy  = rand_coord();
            sel = $urandom_range(0, 9);
            no_gaps = (i % 100) >= 80;
            if (sel < 5)
                send_points(sx, sy, rand_coord(), rand_coord());
            else if (sel < 8)
                // short vectors exercise the low end of the length range
                send_points(sx, sy, sx + $urandom_range(0, 6) - 3,
                            sy + $urandom_range(0, 6) - 3);
            else if (sel < 9)
                send_points(sx, sy, rand_coord(), sy);
            else
                send_points(sx, sy, sx, sy);
        end
        no_gaps = 1'b0;
    endtask

    // more requests than the front, queue and pipeline can hold together
    task automatic test_result_hold();
        hold_request = 300;
        no_gaps      = 1'b1;
        for (int i = 0; i < 80; i++)
            send_points(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        req_valid <= 1'b0;
        wait (expected_res_q.size() == 0);
        @(posedge clk);
        for (int i = 0; i < 10; i++)
            send_points(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // result side: random stalls, long hold-off on demand, and checking
    initial
    begin : result_side
        int   stall_left;
        res_t exp_r;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (expected_res_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result %p", res);
                end
                else
                begin
                    exp_r = expected_res_q.pop_front();
                    if (res.length_q8 !== exp_r.length_q8 || res.dir_x_q14 !== exp_r.dir_x_q14
                        || res.dir_y_q14 !== exp_r.dir_y_q14
                        || res.zero_length !== exp_r.zero_length)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result mismatch: expected %p, got %p", exp_r, res);
                    end
                end
            end
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        res_stall    = 1'b0;
        mismatch_cnt = 0;
        hold_request = 0;
        no_gaps      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(520);
        test_result_hold();
        test_drain_pause();
        test_random(40);

        req_valid <= 1'b0;
        wait (expected_res_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && expected_res_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> vector_normalize_2d.f
rtl/core/vn_pkg.sv
rtl/core/vn_queue.sv
rtl/core/vn_front.sv
rtl/core/vn_back.sv
rtl/core/vector_normalize_2d.sv
tb/tb_vector_normalize_2d.sv
